### rtl/core/mcc_pkg.sv
// shared types, codes and crater mask tables for the masked crater clear block
`default_nettype none

package mcc_pkg;

    // block dimensions (defaults for the top level parameters)
    localparam int BARRIER_HEIGHT_D = 16;
    localparam int BARRIER_WIDTH_D  = 32;
    localparam int BARRIER_COUNT_D  = 4;

    // stream payload widths
    localparam int IN_TDATA_W   = 56;
    localparam int IN_TUSER_W   = 3;
    localparam int OUT_TDATA_W  = 32;
    localparam int OUT_TUSER_W  = 1;

    // command codes
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_BLAST = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // sequencer states
    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_READ   = 6'b000100,
        S_WRITE  = 6'b001000,
        S_BLAST  = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    typedef logic [7:0] t_mask_row;

    // bit i of an entry is mask column i; the invader mask has only seven rows
    localparam t_mask_row INV_MASK [8] = '{
        8'h11, 8'h2C, 8'h1E, 8'h1D, 8'h3E, 8'h1D, 8'h2A, 8'h00
    };
    localparam t_mask_row DEF_MASK [8] = '{
        8'h91, 8'h44, 8'h7E, 8'hFF, 8'hFF, 8'h7E, 8'h00, 8'h81
    };

    function automatic t_mask_row mask_row(input logic kind, input logic [2:0] j);
        mask_row = kind ? DEF_MASK[j] : INV_MASK[j];
    endfunction

endpackage

`default_nettype wire

### rtl/core/mcc_row_mem.sv
// row word memory: one write port, one read port with registered read data
`default_nettype none

module mcc_row_mem #(
    parameter int W     = 32,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/masked_crater_clear_top.sv
// top level: row bitmap store with crater stamping under a small sequencer
// sequence: write and read items pass through S_WRITE or S_READ and then S_FINISH;
//   blast items stay in S_BLAST for each mask row and then pass to S_FINISH
// throughput: one item at a time; a blast reads one mask row per cycle from the
//   row memory read port while the previous row is written back on the write port
// reset: synchronous active-low; afterwards a clearing pass zeroes the row memory,
//   one row per cycle over all BARRIER_COUNT * BARRIER_HEIGHT rows, before items are taken
`default_nettype none

module masked_crater_clear_top import mcc_pkg::*; #(
    parameter int BARRIER_HEIGHT = BARRIER_HEIGHT_D,
    parameter int BARRIER_WIDTH  = BARRIER_WIDTH_D,
    parameter int BARRIER_COUNT  = BARRIER_COUNT_D
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // barrier_index[1:0], row_index[5:2], row_bits[37:6], center_x[44:38],
    // center_y[50:45], zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // cmd[1:0], blast_kind[2]
    input  wire logic [IN_TUSER_W-1:0]  i_s_tuser,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // read_bits[31:0]
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    // done_res[0]
    output logic [OUT_TUSER_W-1:0]      o_m_tuser
);

    localparam int DEPTH = BARRIER_COUNT * BARRIER_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int W     = BARRIER_WIDTH;
    localparam logic [3:0]        COUNT_L  = 4'(BARRIER_COUNT);
    localparam logic [7:0]        HEIGHT_U = 8'(BARRIER_HEIGHT);
    localparam logic signed [7:0] HEIGHT_S = 8'(BARRIER_HEIGHT);
    localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);

    // input fields
    logic [1:0]         in_cmd;
    logic [1:0]         in_b;
    logic [3:0]         in_row;
    logic [31:0]        in_bits;
    logic [6:0]         in_cx;
    logic [5:0]         in_cy;
    logic               in_kind;

    assign in_cmd  = i_s_tuser[1:0];
    assign in_kind = i_s_tuser[2];
    assign in_b    = i_s_tdata[1:0];
    assign in_row  = i_s_tdata[5:2];
    assign in_bits = i_s_tdata[37:6];
    assign in_cx   = i_s_tdata[44:38];
    assign in_cy   = i_s_tdata[50:45];

    t_state r_state, n_state;

    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [3:0]    r_j, n_j;
    logic          r_done, n_done;
    logic          r_is_read, n_is_read;
    logic [1:0]    r_b, n_b;
    logic [AW-1:0] r_addr, n_addr;
    logic [W-1:0]  r_wbits, n_wbits;
    logic [6:0]    r_cx, n_cx;
    logic [5:0]    r_cy, n_cy;
    logic          r_kind, n_kind;

    // blast write-back stage
    logic          r_s1_valid, n_s1_valid;
    logic [AW-1:0] r_s1_addr, n_s1_addr;
    logic [W-1:0]  r_s1_clr, n_s1_clr;

    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_out_bits, n_out_bits;
    logic          r_out_done, n_out_done;

    logic          accept;
    logic          b_ok;
    logic          row_ok_in;
    logic [AW-1:0] in_addr;
    logic [63:0]   in_bits_ext;

    logic signed [7:0] off;
    logic signed [7:0] blast_row;
    logic signed [7:0] ox;
    logic              blast_row_ok;
    logic [AW-1:0]     blast_addr;
    t_mask_row         mrow;
    logic [W-1:0]      col_clr;
    logic [3:0]        blast_last;
    logic signed [9:0] d;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [W-1:0]  mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [W-1:0]  mem_rdata;
    logic [63:0]   rdata_ext;
    logic          out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    assign b_ok        = {2'b00, in_b} < COUNT_L;
    assign row_ok_in   = {4'b0000, in_row} < HEIGHT_U;
    assign in_addr     = AW'(32'(in_b) * 32'(BARRIER_HEIGHT) + 32'(in_row));
    assign in_bits_ext = 64'(in_bits);

    // blast row and column geometry for mask row r_j
    always_comb begin
        off          = r_kind ? 8'sd4 : 8'sd3;
        blast_row    = $signed({{2{r_cy[5]}}, r_cy}) - off + $signed({4'b0000, r_j});
        blast_row_ok = (blast_row >= 8'sd0) && (blast_row < HEIGHT_S);
        blast_addr   = AW'(32'(r_b) * 32'(BARRIER_HEIGHT) + 32'(blast_row[6:0]));
        ox           = $signed({r_cx[6], r_cx}) - off;
        mrow         = mask_row(r_kind, r_j[2:0]);
        blast_last   = r_kind ? 4'd7 : 4'd6;
        col_clr      = '0;
        for (int c = 0; c < W; c++) begin
            d = $signed(10'(c)) - $signed({{2{ox[7]}}, ox});
            if (d >= 10'sd0 && d < 10'sd8) begin
                col_clr[c] = mrow[d[2:0]];
            end
        end
    end

    // memory ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_wbits;
        priority if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (r_s1_valid) begin
            mem_we    = 1'b1;
            mem_waddr = r_s1_addr;
            mem_wdata = mem_rdata & ~r_s1_clr;
        end else if (r_state == S_WRITE) begin
            mem_we    = 1'b1;
        end else begin
            mem_we    = 1'b0;
        end
        mem_re    = 1'b0;
        mem_raddr = r_addr;
        if (r_state == S_READ) begin
            mem_re = 1'b1;
        end else if (r_state == S_BLAST) begin
            mem_re    = blast_row_ok;
            mem_raddr = blast_addr;
        end
    end

    assign rdata_ext = 64'(mem_rdata);

    mcc_row_mem #(
        .W     (W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_j         = r_j;
        n_done      = r_done;
        n_is_read   = r_is_read;
        n_b         = r_b;
        n_addr      = r_addr;
        n_wbits     = r_wbits;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_kind      = r_kind;
        n_s1_valid  = 1'b0;
        n_s1_addr   = r_s1_addr;
        n_s1_clr    = r_s1_clr;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_bits  = r_out_bits;
        n_out_done  = r_out_done;

        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_b       = in_b;
                    n_addr    = in_addr;
                    n_wbits   = in_bits_ext[W-1:0];
                    n_cx      = in_cx;
                    n_cy      = in_cy;
                    n_kind    = in_kind;
                    n_j       = '0;
                    n_is_read = 1'b0;
                    n_done    = 1'b0;
                    n_state   = S_FINISH;
                    if (b_ok) begin
                        unique case (t_cmd'(in_cmd))
                            CMD_WRITE: begin
                                if (row_ok_in) begin
                                    n_done  = 1'b1;
                                    n_state = S_WRITE;
                                end
                            end
                            CMD_READ: begin
                                if (row_ok_in) begin
                                    n_done    = 1'b1;
                                    n_is_read = 1'b1;
                                    n_state   = S_READ;
                                end
                            end
                            CMD_BLAST: begin
                                n_done  = 1'b1;
                                n_state = S_BLAST;
                            end
                            CMD_NONE: begin
                                n_done = 1'b0;
                            end
                        endcase
                    end
                end
            end
            S_READ: begin
                n_state = S_FINISH;
            end
            S_WRITE: begin
                n_state = S_FINISH;
            end
            S_BLAST: begin
                // read this mask row now, write it back masked next cycle
                n_s1_valid = blast_row_ok;
                n_s1_addr  = blast_addr;
                n_s1_clr   = col_clr;
                n_j        = r_j + 1'b1;
                if (r_j == blast_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_done  = r_done;
                    n_out_bits  = (r_is_read && r_done) ? rdata_ext[31:0] : 32'd0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_j         <= '0;
            r_done      <= 1'b0;
            r_is_read   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_j         <= n_j;
            r_done      <= n_done;
            r_is_read   <= n_is_read;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b        <= n_b;
        r_addr     <= n_addr;
        r_wbits    <= n_wbits;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_kind     <= n_kind;
        r_s1_addr  <= n_s1_addr;
        r_s1_clr   <= n_s1_clr;
        r_out_bits <= n_out_bits;
        r_out_done <= n_out_done;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_bits;
    assign o_m_tuser  = r_out_done;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready)
        else $error("item taken during the clearing pass");

    a_writeback_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(r_state == S_BLAST))
        else $error("blast write-back without a preceding row read");

    a_blast_starts_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLAST && r_j == 4'd0) |-> $past(i_s_tvalid && o_s_tready))
        else $error("blast sequence started without an accepted item");

    a_not_done_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("rejected item returned nonzero row bits");

endmodule

`default_nettype wire
